>>> design/pcbd_pkg.sv
// shared types, sizes and codes of the prefix code bit decoder
`timescale 1ns / 1ps
package pcbd_pkg;

  localparam int SYMBOL_COUNT = 256;
  localparam int MAX_CODE_LEN = 16;
  localparam int NODE_DEPTH   = 512;

  localparam int NODE_AW    = $clog2(NODE_DEPTH);
  localparam int NU_W       = $clog2(NODE_DEPTH + 1);
  localparam int VAL_W      = (NODE_AW > 8) ? NODE_AW : 8;
  localparam int POS_W      = (MAX_CODE_LEN > 2) ? $clog2(MAX_CODE_LEN) : 1;
  localparam int CODE_EXT_W = 1 << POS_W;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_BIT   = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KIND_EMPTY = 2'd0,
    KIND_NODE  = 2'd1,
    KIND_LEAF  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [VAL_W-1:0] val;
  } child_t;

  // index 0 is the left child, index 1 the right
  typedef child_t [1:0] node_t;

  localparam int NODE_W = $bits(node_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_BIT
  } state_t;

endpackage

>>> design/prefix_code_bit_decoder.sv
// Prefix code decoder that walks a code tree kept in one node memory.
// A bit item reads the current node in its accept cycle and steps to the
// child in the next cycle. A load item walks the code digits from the most
// significant down, reading each node already on its path through the single
// read port; a new node is linked from its parent and written, empty but for
// the next link or the leaf, in the following cycle. A clear item needs no sweep:
// only the root is guarded by a flag, and every new node is written in full
// before it can be read. No item is taken while a finished result waits
// unaccepted in the output register.
`timescale 1ns / 1ps
module prefix_code_bit_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_func,
  input  logic [7:0] in_symbol,
  input  logic [15:0] in_code,
  input  logic [4:0] in_code_length,
  input  logic       in_bit_req,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_symbol_valid,
  output logic [7:0] out_decoded_symbol,
  output logic [1:0] out_status
);
  import pcbd_pkg::*;

  state_t state_r, state_nxt;

  logic [NODE_AW-1:0] node_r, node_nxt;
  logic [NODE_AW-1:0] cur_r, cur_nxt;
  logic [NU_W-1:0]    used_r, used_nxt;
  logic               root_ok_r, root_ok_nxt;
  logic               zero_r, zero_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [15:0]        code_r, code_nxt;
  logic [7:0]         sym_r, sym_nxt;
  logic               bit_r, bit_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic       res_sv_r, res_sv_nxt;
  logic [7:0] res_sym_r, res_sym_nxt;
  logic [1:0] res_st_r, res_st_nxt;

  logic               ram_we, ram_re;
  logic [NODE_AW-1:0] ram_waddr, ram_raddr;
  node_t              ram_wdata, ram_rdata, rd_eff, wnode;

  logic                  accept, out_busy, bad_load, digit, last, full;
  logic [CODE_EXT_W-1:0] code_ext;
  child_t                ch;

  pcbd_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODE_DEPTH)
  ) u_nodes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_busy = out_valid_r && !out_ready;
  assign in_ready = (state_r == ST_IDLE) && !out_busy;
  assign accept   = in_valid && in_ready;

  assign out_valid          = out_valid_r;
  assign out_symbol_valid   = res_sv_r;
  assign out_decoded_symbol = res_sym_r;
  assign out_status         = res_st_r;

  assign bad_load = (in_code_length == 5'd0)
                 || ({1'b0, in_code_length} > 6'(MAX_CODE_LEN))
                 || (9'(in_symbol) >= 9'(SYMBOL_COUNT));

  // a fresh node or an unwritten root reads as all children empty
  assign rd_eff = (zero_r || (node_r == '0 && !root_ok_r)) ? '0 : ram_rdata;

  assign code_ext = CODE_EXT_W'(code_r);
  assign digit    = (state_r == ST_BIT) ? bit_r : code_ext[pos_r];
  assign last     = (pos_r == '0);
  assign full     = (used_r >= NU_W'(NODE_DEPTH));
  assign ch       = rd_eff[digit];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_func)
            FUNC_LOAD: state_nxt = bad_load ? ST_IDLE : ST_LOAD;
            FUNC_BIT:  state_nxt = ST_BIT;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LOAD: begin
        if (last || (ch.kind != KIND_NODE
            && (zero_r || (ch.kind == KIND_NODE)) == 1'b0 && full)) begin
          state_nxt = ST_IDLE;
        end else if (ch.kind != KIND_NODE && full) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_BIT:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    node_nxt      = node_r;
    cur_nxt       = cur_r;
    used_nxt      = used_r;
    root_ok_nxt   = root_ok_r;
    zero_nxt      = zero_r;
    pos_nxt       = pos_r;
    code_nxt      = code_r;
    sym_nxt       = sym_r;
    bit_nxt       = bit_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_sv_nxt    = res_sv_r;
    res_sym_nxt   = res_sym_r;
    res_st_nxt    = res_st_r;
    ram_we        = 1'b0;
    ram_waddr     = node_r;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    wnode         = rd_eff;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_func)
            FUNC_LOAD: begin
              if (bad_load) begin
                out_valid_nxt = 1'b1;
                res_sv_nxt    = 1'b0;
                res_sym_nxt   = '0;
                res_st_nxt    = STATUS_OK;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                node_nxt  = '0;
                zero_nxt  = 1'b0;
                pos_nxt   = POS_W'(in_code_length - 5'd1);
                code_nxt  = in_code;
                sym_nxt   = in_symbol;
              end
            end
            FUNC_BIT: begin
              ram_re    = 1'b1;
              ram_raddr = cur_r;
              node_nxt  = cur_r;
              zero_nxt  = 1'b0;
              bit_nxt   = in_bit_req;
            end
            FUNC_CLEAR: begin
              used_nxt    = NU_W'(1);
              root_ok_nxt = 1'b0;
              cur_nxt     = '0;
            end
            default: ;
          endcase
        end
      end
      ST_LOAD: begin
        if (last) begin
          wnode[digit].kind = KIND_LEAF;
          wnode[digit].val  = VAL_W'(sym_r);
          ram_we        = 1'b1;
          out_valid_nxt = 1'b1;
          res_sv_nxt    = 1'b0;
          res_sym_nxt   = '0;
          res_st_nxt    = STATUS_OK;
          if (node_r == '0) begin
            root_ok_nxt = 1'b1;
          end
        end else if (ch.kind == KIND_NODE
                     && (NU_W + 1)'(ch.val) < (NU_W + 1)'(NODE_DEPTH)) begin
          ram_re    = 1'b1;
          ram_raddr = NODE_AW'(ch.val);
          node_nxt  = NODE_AW'(ch.val);
          pos_nxt   = pos_r - POS_W'(1);
          zero_nxt  = 1'b0;
        end else if (full) begin
          // a node made in this walk is still unwritten: store it empty
          wnode         = '0;
          ram_we        = zero_r;
          out_valid_nxt = 1'b1;
          res_sv_nxt    = 1'b0;
          res_sym_nxt   = '0;
          res_st_nxt    = STATUS_FULL;
        end else begin
          wnode[digit].kind = KIND_NODE;
          wnode[digit].val  = VAL_W'(used_r);
          ram_we   = 1'b1;
          node_nxt = NODE_AW'(used_r);
          used_nxt = used_r + NU_W'(1);
          pos_nxt  = pos_r - POS_W'(1);
          zero_nxt = 1'b1;
          if (node_r == '0) begin
            root_ok_nxt = 1'b1;
          end
        end
      end
      ST_BIT: begin
        if (ch.kind == KIND_LEAF) begin
          cur_nxt       = '0;
          out_valid_nxt = 1'b1;
          res_sv_nxt    = 1'b1;
          res_sym_nxt   = ch.val[7:0];
          res_st_nxt    = STATUS_OK;
        end else if (ch.kind == KIND_NODE
                     && (NU_W + 1)'(ch.val) < (NU_W + 1)'(NODE_DEPTH)) begin
          cur_nxt = NODE_AW'(ch.val);
        end else begin
          cur_nxt       = '0;
          out_valid_nxt = 1'b1;
          res_sv_nxt    = 1'b0;
          res_sym_nxt   = '0;
          res_st_nxt    = STATUS_EMPTY;
        end
      end
      default: ;
    endcase
    ram_wdata = wnode;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= '0;
      used_r      <= NU_W'(1);
      root_ok_r   <= 1'b0;
      zero_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      used_r      <= used_nxt;
      root_ok_r   <= root_ok_nxt;
      zero_r      <= zero_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r    <= node_nxt;
    pos_r     <= pos_nxt;
    code_r    <= code_nxt;
    sym_r     <= sym_nxt;
    bit_r     <= bit_nxt;
    res_sv_r  <= res_sv_nxt;
    res_sym_r <= res_sym_nxt;
    res_st_r  <= res_st_nxt;
  end

endmodule

>>> design/pcbd_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module pcbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
